// ----- design/assert_macros.svh -----
// Assertion macros used by the RTL of the piecewise tanh / sech^2 unit.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked out of reset
`define CHK_IMPLY(lbl, clk_i, rst_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset
`define CHK_NEXT(lbl, clk_i, rst_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define CHK_IMPLY(lbl, clk_i, rst_i, ante, cons)
`define CHK_NEXT(lbl, clk_i, rst_i, ante, cons)

`endif

`endif

// ----- design/ptsu_pkg.sv -----
// Package for the piecewise tanh / sech^2 unit: widths, breakpoints,
// segment slope and offset tables. No dependencies.
`default_nettype none

package ptsu_pkg;

  localparam int XW        = 32;  // Q11.21 argument
  localparam int TanhW     = 12;  // Q2.10 result
  localparam int SechW     = 24;  // Q3.21 result
  localparam int SlopeW    = 22;  // signed Q1.21 slope
  localparam int OffsetW   = 45;  // signed Q2.43 offset
  localparam int TanhEdges = 11;
  localparam int SechEdges = 13;
  localparam int SegW      = 4;   // index over up to 14 segments
  localparam int TanhShift = 33;
  localparam int SechShift = 22;

  typedef logic signed [XW-1:0]      x_t;
  typedef logic signed [SlopeW-1:0]  slope_t;
  typedef logic signed [OffsetW-1:0] offset_t;
  typedef logic [SegW-1:0]           seg_idx_t;

  // Segment choice handed from the breakpoint compare to the evaluator
  typedef struct packed {
    seg_idx_t tanh_idx;
    seg_idx_t sech_idx;
  } seg_sel_t;

  localparam x_t TANH_EDGE [TanhEdges] = '{
    -32'sd6291456, -32'sd4194304, -32'sd3145728, -32'sd2097152, -32'sd1048576,
    32'sd0, 32'sd1048576, 32'sd2097152, 32'sd3145728, 32'sd4194304, 32'sd6291456
  };

  localparam x_t SECH_EDGE [SechEdges] = '{
    -32'sd6291456, -32'sd4194304, -32'sd3145728, -32'sd2097152, -32'sd1048576,
    -32'sd419430, 32'sd0, 32'sd419430, 32'sd1048576, 32'sd2097152,
    32'sd3145728, 32'sd4194304, 32'sd6291456
  };

  function automatic slope_t tanh_slope(input seg_idx_t idx);
    slope_t s;
    unique case (idx)
      4'd0, 4'd11: s = 22'sd1536;
      4'd1, 4'd10: s = 22'sd61440;
      4'd2, 4'd9:  s = 22'sd243199;
      4'd3, 4'd8:  s = 22'sd596479;
      4'd4, 4'd7:  s = 22'sd1243647;
      4'd5, 4'd6:  s = 22'sd1998335;
      default:     s = '0;
    endcase
    return s;
  endfunction

  function automatic offset_t tanh_offset(input seg_idx_t idx);
    offset_t o;
    unique case (idx)
      4'd0:       o = -45'sd8796093022208;
      4'd1:       o = -45'sd7971899106027;
      4'd2:       o = -45'sd6597069766656;
      4'd3:       o = -45'sd4398046511104;
      4'd4:       o = -45'sd1649267441664;
      4'd7:       o = 45'sd1649267441664;
      4'd8:       o = 45'sd4398046511104;
      4'd9:       o = 45'sd6597069766656;
      4'd10:      o = 45'sd7971899106027;
      4'd11:      o = 45'sd8796093022208;
      default:    o = '0;  // center segments pass through the origin
    endcase
    return o;
  endfunction

  function automatic slope_t sech_slope(input seg_idx_t idx);
    slope_t s;
    unique case (idx)
      4'd0:    s = 22'sd8115;
      4'd1:    s = 22'sd118313;
      4'd2:    s = 22'sd449105;
      4'd3:    s = 22'sd988194;
      4'd4:    s = 22'sd1552234;
      4'd5:    s = 22'sd1255513;
      4'd6:    s = 22'sd450119;
      4'd7:    s = -22'sd450119;
      4'd8:    s = -22'sd1255513;
      4'd9:    s = -22'sd1552234;
      4'd10:   s = -22'sd988194;
      4'd11:   s = -22'sd449105;
      4'd12:   s = -22'sd118313;
      4'd13:   s = -22'sd8115;
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic offset_t sech_offset(input seg_idx_t idx);
    offset_t o;
    unique case (idx)
      4'd0, 4'd13: o = 45'sd157450065097;
      4'd1, 4'd12: o = 45'sd1513807609121;
      4'd2, 4'd11: o = 45'sd4332955422739;
      4'd3, 4'd10: o = 45'sd7708016315360;
      4'd4, 4'd9:  o = 45'sd10152450566232;
      4'd5, 4'd8:  o = 45'sd9603574361646;
      4'd6, 4'd7:  o = 45'sd8867341375687;
      default:     o = '0;
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

// ----- design/ptsu_seg_select.sv -----
// Breakpoint compare for the piecewise tanh / sech^2 unit: picks the
// segment of each function. Depends on ptsu_pkg.
`default_nettype none

module ptsu_seg_select (
  input  wire ptsu_pkg::x_t     x,
  output ptsu_pkg::seg_sel_t    sel
);
  import ptsu_pkg::*;

  // Count edges at or below x; edges are sorted, so the last hit wins
  always_comb begin
    sel = '0;
    for (int i = 0; i < TanhEdges; i++) begin
      if (x >= TANH_EDGE[i]) begin
        sel.tanh_idx = SegW'(i + 1);
      end
    end
    for (int i = 0; i < SechEdges; i++) begin
      if (x >= SECH_EDGE[i]) begin
        sel.sech_idx = SegW'(i + 1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/piecewise_tanh_sech2_unit.sv -----
// Piecewise linear tanh (Q2.10) and sech^2 (Q3.21) of a Q11.21 argument.
// An accepted argument passes the input register, then the result register;
// one item per cycle, stalling only while both stages are full and out_ready is low.
// The segment compare runs ahead of the input register; slope multiply,
// offset add and shift run between the input and result registers.
// Reset (rst, synchronous) empties both stages; no other state is kept.
`default_nettype none
`include "assert_macros.svh"

module piecewise_tanh_sech2_unit (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire ptsu_pkg::x_t              x_value,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic signed [ptsu_pkg::TanhW-1:0] tanh_value,
  output logic signed [ptsu_pkg::SechW-1:0] sech_squared_value
);
  import ptsu_pkg::*;

  localparam int ProdW = XW + SlopeW;  // slope * x
  localparam int SumW  = ProdW + 2;    // doubled product plus offset

  seg_sel_t sel_in;
  seg_sel_t sel_q;
  x_t       x_q;
  logic     stage_valid;
  logic     out_adv;

  slope_t            t_slope, s_slope;
  logic signed [ProdW-1:0] t_prod, s_prod;
  logic signed [SumW-1:0]  t_sum, s_sum;

  ptsu_seg_select u_seg (
    .x   (x_value),
    .sel (sel_in)
  );

  // Result register frees up when empty or being taken
  assign out_adv  = !out_valid || out_ready;
  assign in_ready = !stage_valid || out_adv;

  // Input stage: hold argument and chosen segments
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_q   <= x_value;
      sel_q <= sel_in;
    end
  end

  // Evaluate slope * x * 2 + offset for both functions
  always_comb begin
    t_slope = tanh_slope(sel_q.tanh_idx);
    s_slope = sech_slope(sel_q.sech_idx);
    t_prod  = ProdW'(t_slope) * ProdW'(x_q);
    s_prod  = ProdW'(s_slope) * ProdW'(x_q);
    t_sum   = $signed({t_prod[ProdW-1], t_prod, 1'b0})
              + SumW'(tanh_offset(sel_q.tanh_idx));
    s_sum   = $signed({s_prod[ProdW-1], s_prod, 1'b0})
              + SumW'(sech_offset(sel_q.sech_idx));
  end

  // Result stage: floor shift is a plain bit select of the sum
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && stage_valid) begin
      tanh_value         <= t_sum[TanhShift +: TanhW];
      sech_squared_value <= s_sum[SechShift +: SechW];
    end
  end

  // Checks
  `CHK_NEXT(a_in_fills_stage, clk, rst, in_valid && in_ready, stage_valid)
  `CHK_NEXT(a_stage_to_out, clk, rst, stage_valid && out_adv, out_valid)
  `CHK_IMPLY(a_stall_only_full, clk, rst, !in_ready, stage_valid && out_valid && !out_ready)
  `CHK_NEXT(a_drain_empties, clk, rst, out_valid && out_ready && !stage_valid, !out_valid)

endmodule

`default_nettype wire
